// File: src/mwms_pkg.sv
package mwms_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int TIME_W         = 64;
    localparam int CFG_W          = 9;
    localparam int MEAN_W         = 24;
    localparam int DEV_W          = 23;
    localparam int FRAC_BITS      = 8;
    localparam int DEF_MAX_WINDOW = 256;
    localparam int IN_DATA_W      = 80;
    localparam int OUT_DATA_W     = 112;

    localparam logic [DEV_W-1:0] DEV_MAX = {DEV_W{1'b1}};

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_CALC = 3'b010,
        F_PUSH = 3'b100
    } front_state_t;

    typedef enum logic [5:0] {
        B_IDLE = 6'b000001,
        B_PROD = 6'b000010,
        B_VAR  = 6'b000100,
        B_RUN  = 6'b001000,
        B_DEV  = 6'b010000,
        B_OUT  = 6'b100000
    } back_state_t;

    typedef struct packed {
        logic done;
        logic rem_nz;
    } div_stat_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

// File: src/mwms_front.sv
module mwms_front #(
    parameter int MAX_WINDOW = mwms_pkg::DEF_MAX_WINDOW,
    parameter int NW         = $clog2(MAX_WINDOW + 1),
    parameter int SUM_W      = mwms_pkg::SAMPLE_W + $clog2(MAX_WINDOW) + 1,
    parameter int SQ_W       = 2 * mwms_pkg::SAMPLE_W + $clog2(MAX_WINDOW),
    parameter int ENT_W      = SUM_W + SQ_W + NW + mwms_pkg::TIME_W
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mwms_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mwms_pkg::CFG_W-1:0]    cfg_data,
    output logic                          q_push,
    output logic [ENT_W-1:0]              q_data,
    input  mwms_pkg::queue_stat_t         q_stat
);

    localparam int SW = mwms_pkg::SAMPLE_W;
    localparam int PW = $clog2(MAX_WINDOW);

    mwms_pkg::front_state_t state_reg, state_next;

    logic signed [SW-1:0]   x_reg;
    logic [mwms_pkg::TIME_W-1:0] time_reg;
    logic                   full_reg;
    logic [NW-1:0]          len_reg, len_next;
    logic [NW-1:0]          fill_reg, fill_next;
    logic [PW-1:0]          oldest_reg, oldest_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [SQ_W-1:0]        sq_reg, sq_next;
    logic signed [SW-1:0]   rd_data_reg;
    logic signed [SW-1:0]   ring [MAX_WINDOW];

    logic [NW:0]            slot_sum;
    logic [PW-1:0]          slot;
    logic                   wr_en;
    logic signed [2*SW-1:0] x_sq, old_sq;
    logic [NW-1:0]          len_c;

    assign s_tready  = (state_reg == mwms_pkg::F_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == mwms_pkg::F_IDLE);
    assign q_push    = (state_reg == mwms_pkg::F_PUSH) && !q_stat.full;
    assign q_data    = {time_reg, fill_reg, sq_reg, sum_reg};

    assign x_sq   = x_reg * x_reg;
    assign old_sq = rd_data_reg * rd_data_reg;

    always_comb begin
        if (cfg_data == '0) begin
            len_c = NW'(1);
        end else if (32'(cfg_data) > 32'(MAX_WINDOW)) begin
            len_c = NW'(MAX_WINDOW);
        end else begin
            len_c = NW'(cfg_data);
        end
    end

    always_comb begin
        slot_sum = (NW + 1)'(oldest_reg) + (NW + 1)'(fill_reg);
        if (slot_sum >= (NW + 1)'(len_reg)) begin
            slot_sum = slot_sum - (NW + 1)'(len_reg);
        end
        slot = full_reg ? oldest_reg : slot_sum[PW-1:0];
    end

    always_comb begin
        state_next  = state_reg;
        len_next    = len_reg;
        fill_next   = fill_reg;
        oldest_next = oldest_reg;
        sum_next    = sum_reg;
        sq_next     = sq_reg;
        wr_en       = 1'b0;
        case (state_reg)
            mwms_pkg::F_IDLE: begin
                if (cfg_valid) begin
                    len_next    = len_c;
                    fill_next   = '0;
                    oldest_next = '0;
                    sum_next    = '0;
                    sq_next     = '0;
                end else if (s_tvalid) begin
                    state_next = mwms_pkg::F_CALC;
                end
            end
            mwms_pkg::F_CALC: begin
                wr_en    = 1'b1;
                sum_next = sum_reg + {{(SUM_W - SW){x_reg[SW-1]}}, x_reg};
                sq_next  = sq_reg + SQ_W'(unsigned'(x_sq));
                if (full_reg) begin
                    sum_next = sum_next - {{(SUM_W - SW){rd_data_reg[SW-1]}}, rd_data_reg};
                    sq_next  = sq_next - SQ_W'(unsigned'(old_sq));
                    if ((NW + 1)'(oldest_reg) + (NW + 1)'(1) >= (NW + 1)'(len_reg)) begin
                        oldest_next = '0;
                    end else begin
                        oldest_next = oldest_reg + PW'(1);
                    end
                end else begin
                    fill_next = fill_reg + NW'(1);
                end
                state_next = mwms_pkg::F_PUSH;
            end
            mwms_pkg::F_PUSH: begin
                if (!q_stat.full) begin
                    state_next = mwms_pkg::F_IDLE;
                end
            end
            default: begin
                state_next = mwms_pkg::F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= mwms_pkg::F_IDLE;
            len_reg    <= NW'(1);
            fill_reg   <= '0;
            oldest_reg <= '0;
            sum_reg    <= '0;
            sq_reg     <= '0;
        end else begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            fill_reg   <= fill_next;
            oldest_reg <= oldest_next;
            sum_reg    <= sum_next;
            sq_reg     <= sq_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready && !cfg_valid) begin
            x_reg    <= s_tdata[SW-1:0];
            time_reg <= s_tdata[SW +: mwms_pkg::TIME_W];
            full_reg <= (fill_reg >= len_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring[slot] <= x_reg;
        end
        rd_data_reg <= ring[oldest_reg];
    end

endmodule

// File: src/mwms_queue.sv
module mwms_queue #(
    parameter int W = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  logic [W-1:0]          push_data,
    input  logic                  pop,
    output logic [W-1:0]          pop_data,
    output mwms_pkg::queue_stat_t stat
);

    logic [W-1:0] mem [2];
    logic         wptr_reg, rptr_reg;
    logic [1:0]   count_reg;

    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);
    assign pop_data   = mem[rptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (push) begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop) begin
                rptr_reg <= ~rptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wptr_reg] <= push_data;
        end
    end

endmodule

// File: src/mwms_div.sv
module mwms_div #(
    parameter int DVW = 32,
    parameter int NW  = 9
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [DVW-1:0]       dividend,
    input  logic [NW-1:0]        divisor,
    output logic [DVW-1:0]       quotient,
    output mwms_pkg::div_stat_t  stat
);

    localparam int CW = $clog2(DVW + 1);

    logic [DVW-1:0] dvd_reg;
    logic [NW-1:0]  dsr_reg;
    logic [NW-1:0]  rem_reg;
    logic [CW-1:0]  cnt_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [NW:0]    rem_sh;
    logic           bit_ok;

    assign rem_sh      = {rem_reg, dvd_reg[DVW-1]};
    assign bit_ok      = (rem_sh >= {1'b0, dsr_reg});
    assign quotient    = dvd_reg;
    assign stat.done   = done_reg;
    assign stat.rem_nz = (rem_reg != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(DVW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[DVW-2:0], bit_ok};
            rem_reg <= bit_ok ? NW'(rem_sh - {1'b0, dsr_reg}) : rem_sh[NW-1:0];
        end
    end

endmodule

// File: src/mwms_back.sv
module mwms_back #(
    parameter int MAX_WINDOW = mwms_pkg::DEF_MAX_WINDOW,
    parameter int NW         = $clog2(MAX_WINDOW + 1),
    parameter int SUM_W      = mwms_pkg::SAMPLE_W + $clog2(MAX_WINDOW) + 1,
    parameter int SQ_W       = 2 * mwms_pkg::SAMPLE_W + $clog2(MAX_WINDOW),
    parameter int ENT_W      = SUM_W + SQ_W + NW + mwms_pkg::TIME_W
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    output logic                            q_pop,
    input  logic [ENT_W-1:0]                q_data,
    input  mwms_pkg::queue_stat_t           q_stat,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mwms_pkg::OUT_DATA_W-1:0] m_tdata
);

    localparam int VW  = NW + SQ_W;
    localparam int CMW = (VW > 2 * SUM_W) ? VW : 2 * SUM_W;
    localparam int RW  = (VW + 16 + 1) / 2;
    localparam int SCW = $clog2(RW + 1);
    localparam int MDW = SUM_W + mwms_pkg::FRAC_BITS;
    localparam int DVW = (MDW > RW) ? MDW : RW;
    localparam int MW  = mwms_pkg::MEAN_W;
    localparam int DW  = mwms_pkg::DEV_W;
    localparam int TW  = mwms_pkg::TIME_W;

    mwms_pkg::back_state_t state_reg, state_next;

    logic signed [SUM_W-1:0] sum_reg;
    logic [SQ_W-1:0]         sq_reg;
    logic [NW-1:0]           n_reg;
    logic [TW-1:0]           time_reg;
    logic [SUM_W-1:0]        abs_reg;
    logic                    neg_reg;
    logic [VW-1:0]           a_reg;
    logic [2*SUM_W-1:0]      b_reg;
    logic [2*RW-1:0]         rad_reg;
    logic [RW+1:0]           srem_reg;
    logic [RW-1:0]           root_reg;
    logic [SCW-1:0]          scnt_reg;
    logic                    sbusy_reg;
    logic                    mean_ok_reg;
    logic [MW-1:0]           mean_reg;
    logic [DW-1:0]           dev_reg;
    logic                    m_valid_reg;
    logic [mwms_pkg::OUT_DATA_W-1:0] m_data_reg;

    logic [SUM_W-1:0]    abs_c;
    logic [CMW-1:0]      a_ext, b_ext;
    logic [VW-1:0]       v_c;
    logic [RW+1:0]       srem_sh, trial;
    logic                sbit;
    logic                div_start;
    logic [DVW-1:0]      div_dvd;
    logic [DVW-1:0]      div_q;
    mwms_pkg::div_stat_t div_stat;
    logic [DVW-1:0]      mean_mag;
    logic [DVW-1:0]      mean_c;
    logic [DW-1:0]       dev_c;
    logic                out_free;

    assign q_pop    = (state_reg == mwms_pkg::B_IDLE) && !q_stat.empty;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign out_free = !m_valid_reg || m_tready;

    assign abs_c = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign a_ext = CMW'(a_reg);
    assign b_ext = CMW'(b_reg);
    assign v_c   = (a_ext > b_ext) ? VW'(a_ext - b_ext) : '0;

    assign srem_sh = {srem_reg[RW-1:0], rad_reg[2*RW-1 -: 2]};
    assign trial   = {root_reg, 2'b01};
    assign sbit    = (srem_sh >= trial);

    assign div_start = (state_reg == mwms_pkg::B_VAR) ||
                       ((state_reg == mwms_pkg::B_RUN) && !sbusy_reg && mean_ok_reg);
    assign div_dvd   = (state_reg == mwms_pkg::B_VAR) ?
                       DVW'({abs_reg, {mwms_pkg::FRAC_BITS{1'b0}}}) : DVW'(root_reg);

    assign mean_mag = div_q + DVW'(neg_reg && div_stat.rem_nz);
    assign mean_c   = neg_reg ? DVW'(-mean_mag) : mean_mag;
    assign dev_c    = (div_q > DVW'(mwms_pkg::DEV_MAX)) ? mwms_pkg::DEV_MAX : DW'(div_q);

    mwms_div #(
        .DVW(DVW),
        .NW (NW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(div_dvd),
        .divisor (n_reg),
        .quotient(div_q),
        .stat    (div_stat)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mwms_pkg::B_IDLE: begin
                if (!q_stat.empty) begin
                    state_next = mwms_pkg::B_PROD;
                end
            end
            mwms_pkg::B_PROD: begin
                state_next = mwms_pkg::B_VAR;
            end
            mwms_pkg::B_VAR: begin
                state_next = mwms_pkg::B_RUN;
            end
            mwms_pkg::B_RUN: begin
                if (!sbusy_reg && mean_ok_reg) begin
                    state_next = mwms_pkg::B_DEV;
                end
            end
            mwms_pkg::B_DEV: begin
                if (div_stat.done) begin
                    state_next = mwms_pkg::B_OUT;
                end
            end
            mwms_pkg::B_OUT: begin
                if (out_free) begin
                    state_next = mwms_pkg::B_IDLE;
                end
            end
            default: begin
                state_next = mwms_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mwms_pkg::B_IDLE;
            sbusy_reg   <= 1'b0;
            mean_ok_reg <= 1'b0;
            scnt_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == mwms_pkg::B_VAR) begin
                sbusy_reg   <= 1'b1;
                mean_ok_reg <= 1'b0;
                scnt_reg    <= '0;
            end else if (sbusy_reg) begin
                scnt_reg <= scnt_reg + SCW'(1);
                if (scnt_reg == SCW'(RW - 1)) begin
                    sbusy_reg <= 1'b0;
                end
            end
            if ((state_reg == mwms_pkg::B_RUN) && div_stat.done) begin
                mean_ok_reg <= 1'b1;
            end
            if ((state_reg == mwms_pkg::B_OUT) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            sum_reg  <= q_data[SUM_W-1:0];
            sq_reg   <= q_data[SUM_W +: SQ_W];
            n_reg    <= q_data[SUM_W + SQ_W +: NW];
            time_reg <= q_data[SUM_W + SQ_W + NW +: TW];
        end
        if (state_reg == mwms_pkg::B_PROD) begin
            a_reg   <= n_reg * sq_reg;
            b_reg   <= abs_c * abs_c;
            abs_reg <= abs_c;
            neg_reg <= sum_reg[SUM_W-1];
        end
        if (state_reg == mwms_pkg::B_VAR) begin
            rad_reg  <= (2 * RW)'({v_c, 16'h0000});
            srem_reg <= '0;
            root_reg <= '0;
        end else if (sbusy_reg) begin
            rad_reg  <= {rad_reg[2*RW-3:0], 2'b00};
            srem_reg <= sbit ? (srem_sh - trial) : srem_sh;
            root_reg <= {root_reg[RW-2:0], sbit};
        end
        if ((state_reg == mwms_pkg::B_RUN) && div_stat.done) begin
            mean_reg <= mean_c[MW-1:0];
        end
        if ((state_reg == mwms_pkg::B_DEV) && div_stat.done) begin
            dev_reg <= dev_c;
        end
        if ((state_reg == mwms_pkg::B_OUT) && out_free) begin
            m_data_reg <= {1'b0, time_reg, dev_reg, mean_reg};
        end
    end

endmodule

// File: src/moving_window_mean_stddev_top.sv
// A result passes through the front states F_IDLE, F_CALC and F_PUSH, then a bit-serial
// square root running beside the mean division, followed by the deviation division,
// each one bit per cycle. The back part handles one transaction at a time and limits the
// rate; a two-entry queue lets the front run ahead. Reset is synchronous and active low;
// it sets the window length to one and empties it.
module moving_window_mean_stddev_top #(
    parameter int MAX_WINDOW = mwms_pkg::DEF_MAX_WINDOW
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // sample_value [15:0], time_stamp [79:16]
    input  logic [mwms_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // window_mean [23:0], window_stddev [46:24], result_time [110:47]
    output logic [mwms_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mwms_pkg::CFG_W-1:0]      cfg_data
);

    localparam int NW    = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = mwms_pkg::SAMPLE_W + $clog2(MAX_WINDOW) + 1;
    localparam int SQ_W  = 2 * mwms_pkg::SAMPLE_W + $clog2(MAX_WINDOW);
    localparam int ENT_W = SUM_W + SQ_W + NW + mwms_pkg::TIME_W;

    logic                  q_push, q_pop;
    logic [ENT_W-1:0]      q_wdata, q_rdata;
    mwms_pkg::queue_stat_t q_stat;

    mwms_front #(
        .MAX_WINDOW(MAX_WINDOW),
        .NW        (NW),
        .SUM_W     (SUM_W),
        .SQ_W      (SQ_W),
        .ENT_W     (ENT_W)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .q_push   (q_push),
        .q_data   (q_wdata),
        .q_stat   (q_stat)
    );

    mwms_queue #(
        .W(ENT_W)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_data(q_wdata),
        .pop      (q_pop),
        .pop_data (q_rdata),
        .stat     (q_stat)
    );

    mwms_back #(
        .MAX_WINDOW(MAX_WINDOW),
        .NW        (NW),
        .SUM_W     (SUM_W),
        .SQ_W      (SQ_W),
        .ENT_W     (ENT_W)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_pop   (q_pop),
        .q_data  (q_rdata),
        .q_stat  (q_stat),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

endmodule

// File: tb/mwms_checker.sv
`timescale 1ns / 100ps

module mwms_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [mwms_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [mwms_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [mwms_pkg::CFG_W-1:0]      cfg_data,
    output int                              error_count,
    output int                              pending_count
);

    localparam int RING_DEPTH = mwms_pkg::DEF_MAX_WINDOW;

    typedef struct packed {
        logic [mwms_pkg::TIME_W-1:0]  stamp;
        logic [mwms_pkg::DEV_W-1:0]   stddev;
        logic [mwms_pkg::MEAN_W-1:0]  mean;
    } window_stats_t;

    logic signed [mwms_pkg::SAMPLE_W-1:0] ring [RING_DEPTH];
    int unsigned    head_slot;
    int unsigned    filled;
    longint         sum_acc;
    longint unsigned sq_acc;
    logic [mwms_pkg::CFG_W-1:0] length_reg;
    window_stats_t  expected_buf [256];
    logic [31:0]    put_count;
    logic [31:0]    take_count;

    assign pending_count = int'(put_count - take_count);

    function automatic logic [63:0] root_of(input logic [127:0] v);
        logic [63:0]  r;
        logic [63:0]  c;
        logic [127:0] sq;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            sq = 128'(c) * 128'(c);
            if (sq <= v) r = c;
        end
        return r;
    endfunction

    task automatic absorb_sample(input logic [mwms_pkg::IN_DATA_W-1:0] d);
        logic signed [mwms_pkg::SAMPLE_W-1:0] x;
        logic signed [mwms_pkg::SAMPLE_W-1:0] old;
        int unsigned   len;
        int unsigned   slot;
        longint        num;
        longint        q;
        longint unsigned mag;
        logic [127:0]  a;
        logic [127:0]  bq;
        logic [127:0]  v;
        logic [63:0]   dev;
        window_stats_t e;
        x = d[mwms_pkg::SAMPLE_W-1:0];
        len = (length_reg == 0) ? 1 : (length_reg > RING_DEPTH ? RING_DEPTH : length_reg);
        if (filled >= len) begin
            old = ring[head_slot % RING_DEPTH];
            sum_acc -= longint'(old);
            sq_acc -= longint'(old) * longint'(old);
            slot = head_slot % RING_DEPTH;
            head_slot = (head_slot + 1) % len;
            filled = len;
        end else begin
            slot = (head_slot + filled) % len;
            filled++;
        end
        ring[slot] = x;
        sum_acc += longint'(x);
        sq_acc += longint'(x) * longint'(x);
        num = sum_acc * 256;
        q = num / longint'(filled);
        if (num % longint'(filled) != 0 && num < 0) q--;
        if (q > 8388607) q = 8388607;
        if (q < -8388608) q = -8388608;
        mag = sum_acc < 0 ? -sum_acc : sum_acc;
        a = 128'(filled) * 128'(sq_acc);
        bq = 128'(mag) * 128'(mag);
        v = (a <= bq) ? 128'd0 : (a - bq) << 16;
        dev = root_of(v) / filled;
        if (dev > 64'(mwms_pkg::DEV_MAX)) dev = 64'(mwms_pkg::DEV_MAX);
        e.mean = q[mwms_pkg::MEAN_W-1:0];
        e.stddev = dev[mwms_pkg::DEV_W-1:0];
        e.stamp = d[mwms_pkg::SAMPLE_W +: mwms_pkg::TIME_W];
        expected_buf[put_count[7:0]] = e;
        put_count = put_count + 32'd1;
    endtask

    always @(posedge aclk) begin
        window_stats_t got;
        window_stats_t want;
        int            errs;
        errs = 0;
        if (!aresetn) begin
            length_reg = mwms_pkg::CFG_W'(1);
            head_slot = 0;
            filled = 0;
            sum_acc = 0;
            sq_acc = 0;
            put_count = '0;
            take_count = '0;
            error_count <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                length_reg = cfg_data;
                head_slot = 0;
                filled = 0;
                sum_acc = 0;
                sq_acc = 0;
            end
            if (s_tvalid && s_tready) absorb_sample(s_tdata);
            if (m_tvalid && m_tready) begin
                got = m_tdata[$bits(window_stats_t)-1:0];
                if (put_count == take_count) begin
                    $display("%t: unexpected result, expected none, actual %h", $time, got);
                    errs++;
                end else begin
                    want = expected_buf[take_count[7:0]];
                    take_count = take_count + 32'd1;
                    if (got.mean !== want.mean) begin
                        $display("%t: window_mean expected %h actual %h",
                                 $time, want.mean, got.mean);
                        errs++;
                    end
                    if (got.stddev !== want.stddev) begin
                        $display("%t: window_stddev expected %h actual %h",
                                 $time, want.stddev, got.stddev);
                        errs++;
                    end
                    if (got.stamp !== want.stamp) begin
                        $display("%t: result_time expected %h actual %h",
                                 $time, want.stamp, got.stamp);
                        errs++;
                    end
                end
            end
            error_count <= error_count + errs;
        end
    end
endmodule

// File: tb/tb_moving_window_mean_stddev_top.sv
`timescale 1ns / 100ps

module tb_moving_window_mean_stddev_top;

    localparam longint CYCLE_LIMIT = 3000000;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [mwms_pkg::IN_DATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [mwms_pkg::OUT_DATA_W-1:0] m_tdata;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [mwms_pkg::CFG_W-1:0] cfg_data = '0;
    int error_count;
    int pending_count;
    longint cycle_count = 0;
    bit hold_output = 0;

    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    moving_window_mean_stddev_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    mwms_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .error_count(error_count), .pending_count(pending_count)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 150);
    endfunction

    // Result side: random stalls, plus a hold with m_tready low once hold_output is set.
    initial begin
        int g;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_output) begin
                m_tready <= 0;
                repeat (400) @(posedge aclk);
                hold_output = 0;
            end else begin
                g = gap_length();
                if (g > 0) begin
                    m_tready <= 0;
                    repeat (g) @(posedge aclk);
                end
                m_tready <= 1;
                @(posedge aclk);
            end
        end
    end

    task automatic send_sample(input logic [mwms_pkg::SAMPLE_W-1:0] v, input bit with_gaps);
        int g;
        g = with_gaps ? gap_length() : 0;
        if (g > 0) begin
            s_tvalid <= 0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {64'($urandom) << 32 | 64'($urandom), v};
        @(posedge aclk iff s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 0;
        @(posedge aclk);
        @(posedge aclk iff pending_count == 0);
        repeat (120) @(posedge aclk);
    endtask

    task automatic write_length(input logic [mwms_pkg::CFG_W-1:0] len);
        cfg_valid <= 1;
        cfg_data <= len;
        @(posedge aclk iff cfg_ready);
        cfg_valid <= 0;
    endtask

    function automatic logic [mwms_pkg::SAMPLE_W-1:0] random_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'h8000;
        if (r == 1) return 16'h7FFF;
        if (r == 2) return mwms_pkg::SAMPLE_W'(int'($urandom_range(0, 7)) - 3);
        return mwms_pkg::SAMPLE_W'($urandom);
    endfunction

    initial begin
        logic [mwms_pkg::CFG_W-1:0] lengths [8];
        logic [mwms_pkg::SAMPLE_W-1:0] edges [6];
        int len;
        int count;
        lengths = '{9'd1, 9'd256, 9'd0, 9'd511, 9'd257, 9'd2, 9'd5, 9'd17};
        edges = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h8000};
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Default window of one, then extremes with a window of three.
        foreach (edges[i]) send_sample(edges[i], 0);
        wait_drained();
        write_length(3);
        foreach (edges[i]) send_sample(edges[i], 1);
        repeat (6) send_sample(16'h8000, 0);
        repeat (6) send_sample(16'h7FFF, 0);
        wait_drained();

        // Long stall on the result side while the input keeps offering.
        hold_output = 1;
        repeat (10) send_sample(random_sample(), 0);
        wait_drained();

        for (int p = 0; p < 20; p++) begin
            write_length(p < 8 ? lengths[p] : mwms_pkg::CFG_W'($urandom_range(0, 300)));
            len = (p == 3 || p == 4) ? 300 : 50;
            count = (p == 1) ? $urandom_range(280, 300) : $urandom_range(len / 2, len);
            for (int i = 0; i < count; i++) send_sample(random_sample(), 1);
            wait_drained();
        end

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

// File: files.f
src/mwms_pkg.sv
src/mwms_front.sv
src/mwms_queue.sv
src/mwms_div.sv
src/mwms_back.sv
src/moving_window_mean_stddev_top.sv
tb/mwms_checker.sv
tb/tb_moving_window_mean_stddev_top.sv
